FILE: rtl/core/assert_macros.svh
// Assertion macros for the core RTL files.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

FILE: rtl/core/rarst_pkg.sv
// Constants and helpers for the range add / range sum tree.
// Depends on nothing; used by rarst_mul and the top level.
package rarst_pkg;
	localparam int POSITIONS = 1024;
	localparam int POS_W = 10;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;
	// Index tree entries 1..POSITIONS; entry 0 is unused.
	localparam int IDX_W = $clog2(POSITIONS + 1);
	localparam int DEPTH = POSITIONS + 1;
	localparam int WIDE_W = (IDX_W + 1 > POS_W + 2) ? IDX_W + 1 : POS_W + 2;
	localparam int ENTRY_W = 2 * SUM_W;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Lowest set bit of a tree index.
	function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] i);
		return i & (~i + IDX_W'(1));
	endfunction
endpackage

FILE: rtl/core/rarst_ram.sv
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
module rarst_ram #(
	parameter int DW = 8,
	parameter int DEPTH = 16,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/rarst_mul.sv
// Shared registered multiplier: 64-bit word times tree index, low 64 bits.
// Depends on rarst_pkg.
module rarst_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rarst_pkg::SUM_W-1:0]   a,
	input  logic [rarst_pkg::IDX_W-1:0]   b,
	output logic [rarst_pkg::SUM_W-1:0]   prod_q
);
	import rarst_pkg::*;

	logic [SUM_W-1:0] prod;

	assign prod = a * SUM_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod;
		end
	end
endmodule

FILE: rtl/core/range_add_range_sum_tree_top.sv
// Top level of the range add / range sum tree, with its sequencer.
// Depends on rarst_pkg, rarst_ram, rarst_mul and assert_macros.svh.
//
// The block holds POSITIONS 64-bit counters as two indexed binary trees in one
// memory of POSITIONS+1 entries; range adds and range sums wrap modulo 2^64.
// After reset a clearing pass writes every entry, one a cycle, during which no
// word is accepted. One word is worked at a time. An add walks the tree upward
// from two points, each walk taking up to IDX_W = 11 read-modify-write steps
// on the memory port, plus setup. A query walks downward from two points, with
// one pass through the shared multiplier per point. An empty range adds
// nothing and a query over it returns 0.
module range_add_range_sum_tree_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               operation,
	input  logic [rarst_pkg::POS_W-1:0]        range_start,
	input  logic [rarst_pkg::POS_W-1:0]        range_end,
	input  logic signed [rarst_pkg::VAL_W-1:0] add_value,
	output logic                               sum_valid,
	input  logic                               sum_stall,
	output logic signed [rarst_pkg::SUM_W-1:0] range_sum
);
	import rarst_pkg::*;

	typedef enum logic [3:0] {
		CLEAR, IDLE, SETUP, U_MUL, U_RD, U_WR, Q_RD, Q_ACC, Q_MUL, Q_FIN, Q_OUT
	} state_t;

	state_t state_q;
	logic op_q, phase_q, sum_valid_q;
	logic [POS_W-1:0] lo_q, hi_q;
	logic [SUM_W-1:0] v_q, d_q, s1_q, s2_q, acc_q, rsum_q;
	logic [IDX_W-1:0] walk_q, pt_q, clr_q;

	logic [WIDE_W-1:0] pidx_w, next_w;
	logic pidx_ok;
	logic [IDX_W-1:0] pidx_clamp;
	logic [SUM_W-1:0] term;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [SUM_W-1:0] q1, q2;

	logic mul_en;
	logic [SUM_W-1:0] mul_a, prod;
	logic [IDX_W-1:0] mul_b;

	assign item_stall = (state_q != IDLE);
	assign sum_valid = sum_valid_q;
	assign range_sum = rsum_q;

	assign q1 = ram_rdata[SUM_W-1:0];
	assign q2 = ram_rdata[ENTRY_W-1:SUM_W];

	// Points of the current phase: an add touches start+1 and end+2, a query
	// takes prefix sums up to end+1 and up to start.
	always_comb begin
		if (op_q == OP_ADD) begin
			pidx_w = phase_q ? WIDE_W'(hi_q) + WIDE_W'(2) : WIDE_W'(lo_q) + WIDE_W'(1);
		end else begin
			pidx_w = phase_q ? WIDE_W'(lo_q) : WIDE_W'(hi_q) + WIDE_W'(1);
		end
		pidx_ok = (pidx_w <= WIDE_W'(POSITIONS));
		pidx_clamp = pidx_ok ? pidx_w[IDX_W-1:0] : IDX_W'(POSITIONS);
	end

	assign next_w = WIDE_W'(walk_q) + WIDE_W'(low_bit(walk_q));
	assign term = prod - s2_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = walk_q;
		ram_wdata = {q2 + prod, q1 + d_q};
		if (state_q == CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == U_WR) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		mul_en = (state_q == U_MUL) || (state_q == Q_MUL);
		if (state_q == U_MUL) begin
			mul_a = d_q;
			mul_b = walk_q - IDX_W'(1);
		end else begin
			mul_a = s1_q;
			mul_b = pt_q;
		end
	end

	rarst_ram #(.DW(ENTRY_W), .DEPTH(DEPTH), .AW(IDX_W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (walk_q),
		.rdata (ram_rdata)
	);

	rarst_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			clr_q <= '0;
			sum_valid_q <= 1'b0;
			phase_q <= 1'b0;
			op_q <= OP_ADD;
			walk_q <= '0;
		end else begin
			// Q_OUT drives the valid flag itself in the cycle it presents a word.
			if (sum_valid_q && !sum_stall && state_q != Q_OUT) begin
				sum_valid_q <= 1'b0;
			end
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(POSITIONS)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (item_valid) begin
						op_q <= operation;
						lo_q <= range_start;
						hi_q <= range_end;
						v_q <= SUM_W'(add_value);
						phase_q <= 1'b0;
						acc_q <= '0;
						if (range_start > range_end) begin
							state_q <= (operation == OP_QUERY) ? Q_OUT : IDLE;
						end else begin
							state_q <= SETUP;
						end
					end
				end
				SETUP: begin
					walk_q <= pidx_clamp;
					pt_q <= pidx_clamp;
					s1_q <= '0;
					s2_q <= '0;
					d_q <= phase_q ? -v_q : v_q;
					if (op_q == OP_QUERY) begin
						state_q <= Q_RD;
					end else if (pidx_ok) begin
						state_q <= U_MUL;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						state_q <= IDLE;
					end
				end
				U_MUL: state_q <= U_RD;
				U_RD: state_q <= U_WR;
				U_WR: begin
					if (next_w > WIDE_W'(POSITIONS)) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= SETUP;
						end else begin
							state_q <= IDLE;
						end
					end else begin
						walk_q <= next_w[IDX_W-1:0];
						state_q <= U_RD;
					end
				end
				Q_RD: begin
					state_q <= (walk_q == '0) ? Q_MUL : Q_ACC;
				end
				Q_ACC: begin
					s1_q <= s1_q + q1;
					s2_q <= s2_q + q2;
					walk_q <= walk_q - low_bit(walk_q);
					state_q <= Q_RD;
				end
				Q_MUL: state_q <= Q_FIN;
				Q_FIN: begin
					acc_q <= phase_q ? acc_q - term : acc_q + term;
					if (!phase_q) begin
						phase_q <= 1'b1;
						state_q <= SETUP;
					end else begin
						state_q <= Q_OUT;
					end
				end
				Q_OUT: begin
					if (!sum_valid_q || !sum_stall) begin
						rsum_q <= acc_q;
						sum_valid_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`include "assert_macros.svh"

	`ASSERT_SAME(a_no_accept_in_clear, clk, arst_n, state_q == CLEAR, item_stall)
	`ASSERT_SAME(a_write_in_range, clk, arst_n, ram_we, ram_waddr <= IDX_W'(POSITIONS))
	`ASSERT_SAME(a_walk_nonzero, clk, arst_n, state_q == U_RD || state_q == U_WR, walk_q != '0)
	`ASSERT_NEXT(a_rmw_follows_read, clk, arst_n, state_q == U_RD, state_q == U_WR)
endmodule
